/* sv/lrc_pkg.sv */
// Package for the LRU register cache allocator.
// Holds the command codes, the result flag bundle and the default sizes.
// No dependencies.
`timescale 1ns / 1ps

package lrc_pkg;

  // Default sizes, used as parameter defaults on the top level.
  localparam int ENTRIES_DEF     = 8;
  localparam int KEY_WIDTH_DEF   = 16;
  localparam int STAMP_WIDTH_DEF = 32;

  // Fixed field widths of the item and result ports.
  localparam int CMD_W = 2;
  localparam int REG_W = 3;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_USE     = 2'd0,
    CMD_INVAL   = 2'd1,
    CMD_ALLOC   = 2'd2,
    CMD_RELEASE = 2'd3
  } lrc_cmd_t;

  // Status flags of one result item.
  typedef struct packed {
    logic hit;
    logic load_needed;
    logic spill_needed;
    logic pinned;
    logic pool_full;
  } lrc_flags_t;

endpackage

/* sv/lru_register_cache_allocator.sv */
// LRU register cache allocator, top level: input register, decision core
// and result register. Depends on lrc_pkg and lrc_core.
//
// Usage:
// A pool of ENTRIES registers that doubles as a fully associative variable
// cache with least recently used replacement. Each input item carries a
// command (use variable, invalidate variable, allocate temp, release temp)
// with its key, declared flag and release index; each item yields exactly
// one result item with the granted register and status flags.
// Both channels use valid/ready; an item moves on when both are high.
// The result item is shown once its input item has passed the input register
// and then the result register: the lookup, free search and LRU tree resolve
// in a single pass from the input register into the result register, and a
// stall holds the item in the input register. Throughput is one item per cycle
// while out_ready stays high; the pass through the LRU stamp comparison tree
// sets the clock, not the rate.
// Reset (rst_n low, synchronous) frees every entry and temp, clears the
// use clock and empties both registers.
// When the receiver stalls, the result register holds its item, the input
// register takes one more item, and in_ready then drops until out_ready.
`timescale 1ns / 1ps

module lru_register_cache_allocator #(
  parameter int ENTRIES     = lrc_pkg::ENTRIES_DEF,
  parameter int KEY_WIDTH   = lrc_pkg::KEY_WIDTH_DEF,
  parameter int STAMP_WIDTH = lrc_pkg::STAMP_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [lrc_pkg::CMD_W-1:0] in_cmd,
  input  logic [KEY_WIDTH-1:0]      in_var_key,
  input  logic                      in_var_declared,
  input  logic [lrc_pkg::REG_W-1:0] in_release_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [lrc_pkg::REG_W-1:0] out_reg_num,
  output logic                      out_hit,
  output logic                      out_load_needed,
  output logic                      out_spill_needed,
  output logic [KEY_WIDTH-1:0]      out_spill_key,
  output logic                      out_pinned,
  output logic                      out_pool_full
);

  import lrc_pkg::*;

  // Input register.
  logic                 in_vld_r;
  lrc_cmd_t             cmd_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic                 declared_r;
  logic [REG_W-1:0]     rel_r;

  // Result register.
  logic                 out_vld_r;
  logic [REG_W-1:0]     reg_num_r;
  lrc_flags_t           flags_r;
  logic [KEY_WIDTH-1:0] spill_key_r;

  // Core result.
  logic [REG_W-1:0]     res_reg_num;
  lrc_flags_t           res_flags;
  logic [KEY_WIDTH-1:0] res_spill_key;

  logic advance;

  // The held item moves into the result register when that slot frees up.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r      <= lrc_cmd_t'(in_cmd);
      key_r      <= in_var_key;
      declared_r <= in_var_declared;
      rel_r      <= in_release_index;
    end
  end

  // Decision logic and state.
  lrc_core #(
    .ENTRIES     (ENTRIES),
    .KEY_WIDTH   (KEY_WIDTH),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (advance),
    .cmd           (cmd_r),
    .var_key       (key_r),
    .var_declared  (declared_r),
    .release_index (rel_r),
    .res_reg_num   (res_reg_num),
    .res_flags     (res_flags),
    .res_spill_key (res_spill_key)
  );

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      reg_num_r   <= res_reg_num;
      flags_r     <= res_flags;
      spill_key_r <= res_spill_key;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_reg_num      = reg_num_r;
  assign out_hit          = flags_r.hit;
  assign out_load_needed  = flags_r.load_needed;
  assign out_spill_needed = flags_r.spill_needed;
  assign out_spill_key    = spill_key_r;
  assign out_pinned       = flags_r.pinned;
  assign out_pool_full    = flags_r.pool_full;

endmodule

/* sv/lrc_lru_tree.sv */
// Least recently used search over the cache entries: a comparison tree that
// returns the valid entry with the smallest stamp, lowest index on a tie.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module lrc_lru_tree #(
  parameter int ENTRIES     = 8,
  parameter int STAMP_WIDTH = 32,
  parameter int IDX_W       = $clog2(ENTRIES)
) (
  input  logic [ENTRIES-1:0]     entry_valid,
  input  logic [STAMP_WIDTH-1:0] entry_stamp [ENTRIES],
  output logic                   lru_any,
  output logic [IDX_W-1:0]       lru_idx
);

  localparam int LEAVES = 1 << IDX_W;
  localparam int NODES  = 2 * LEAVES - 1;

  // Heap-ordered nodes: node n has children 2n+1 and 2n+2.
  logic                   nd_vld   [NODES];
  logic [STAMP_WIDTH-1:0] nd_stamp [NODES];
  logic [IDX_W-1:0]       nd_idx   [NODES];

  // Leaves: one per entry, padding leaves are never valid.
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < ENTRIES) begin : g_real
      assign nd_vld[LEAVES-1+i]   = entry_valid[i];
      assign nd_stamp[LEAVES-1+i] = entry_stamp[i];
    end else begin : g_pad
      assign nd_vld[LEAVES-1+i]   = 1'b0;
      assign nd_stamp[LEAVES-1+i] = '0;
    end
    assign nd_idx[LEAVES-1+i] = IDX_W'(i);
  end

  // Inner nodes: the left child covers lower indices, so it wins ties.
  for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
    logic take_right;
    assign take_right = nd_vld[2*n+2] &&
                        (!nd_vld[2*n+1] || (nd_stamp[2*n+2] < nd_stamp[2*n+1]));
    assign nd_vld[n]   = nd_vld[2*n+1] | nd_vld[2*n+2];
    assign nd_stamp[n] = take_right ? nd_stamp[2*n+2] : nd_stamp[2*n+1];
    assign nd_idx[n]   = take_right ? nd_idx[2*n+2] : nd_idx[2*n+1];
  end

  assign lru_any = nd_vld[0];
  assign lru_idx = nd_idx[0];

endmodule

/* sv/lrc_core.sv */
// Cache and temp pool state with the per-request decision logic.
// Depends on lrc_pkg and lrc_lru_tree.
`timescale 1ns / 1ps

module lrc_core #(
  parameter int ENTRIES     = lrc_pkg::ENTRIES_DEF,
  parameter int KEY_WIDTH   = lrc_pkg::KEY_WIDTH_DEF,
  parameter int STAMP_WIDTH = lrc_pkg::STAMP_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  lrc_pkg::lrc_cmd_t           cmd,
  input  logic [KEY_WIDTH-1:0]        var_key,
  input  logic                        var_declared,
  input  logic [lrc_pkg::REG_W-1:0]   release_index,
  output logic [lrc_pkg::REG_W-1:0]   res_reg_num,
  output lrc_pkg::lrc_flags_t         res_flags,
  output logic [KEY_WIDTH-1:0]        res_spill_key
);

  import lrc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  // State registers.
  logic [ENTRIES-1:0]     entry_valid_r, entry_valid_nxt;
  logic [ENTRIES-1:0]     pool_busy_r, pool_busy_nxt;
  logic [KEY_WIDTH-1:0]   entry_key_r   [ENTRIES];
  logic [STAMP_WIDTH-1:0] entry_stamp_r [ENTRIES];
  logic [STAMP_WIDTH-1:0] use_clock_r, use_clock_nxt;

  // Match and free vectors.
  logic [ENTRIES-1:0] hit_vec, free_vec, temp_vec;
  logic               hit_any, free_any, temp_any, lru_any;
  logic [IDX_W-1:0]   hit_idx, free_idx, temp_idx, lru_idx;

  // Write controls.
  logic             clock_tick, stamp_we, key_we, use_rel, rel_in_range;
  logic [IDX_W-1:0] stamp_idx, wr_idx, res_idx, rel_idx;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_vec
    assign hit_vec[i]  = entry_valid_r[i] && (entry_key_r[i] == var_key);
    assign free_vec[i] = !entry_valid_r[i] && !pool_busy_r[i];
    assign temp_vec[i] = !pool_busy_r[i];
  end

  assign hit_any  = |hit_vec;
  assign free_any = |free_vec;
  assign temp_any = |temp_vec;

  // Lowest-index priority encoders.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    temp_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i])  hit_idx  = IDX_W'(i);
      if (free_vec[i]) free_idx = IDX_W'(i);
      if (temp_vec[i]) temp_idx = IDX_W'(i);
    end
  end

  // Eviction candidate.
  lrc_lru_tree #(
    .ENTRIES     (ENTRIES),
    .STAMP_WIDTH (STAMP_WIDTH),
    .IDX_W       (IDX_W)
  ) u_lru_tree (
    .entry_valid (entry_valid_r),
    .entry_stamp (entry_stamp_r),
    .lru_any     (lru_any),
    .lru_idx     (lru_idx)
  );

  // Saturating use clock.
  assign use_clock_nxt = (use_clock_r == '1) ? use_clock_r : use_clock_r + 1'b1;

  // Release index range check.
  assign rel_in_range = 32'(release_index) < 32'(ENTRIES);
  assign rel_idx      = IDX_W'(release_index);

  // Request decision.
  always_comb begin
    entry_valid_nxt = entry_valid_r;
    pool_busy_nxt   = pool_busy_r;
    clock_tick      = 1'b0;
    stamp_we        = 1'b0;
    stamp_idx       = hit_idx;
    key_we          = 1'b0;
    wr_idx          = free_any ? free_idx : lru_idx;
    res_idx         = '0;
    use_rel         = 1'b0;
    res_flags       = '0;
    res_spill_key   = '0;
    unique case (cmd)
      CMD_USE: begin
        if (hit_any) begin
          stamp_we           = 1'b1;
          clock_tick         = 1'b1;
          res_idx            = hit_idx;
          res_flags.hit      = 1'b1;
          res_flags.pinned   = 1'b1;
        end else begin
          res_flags.load_needed = var_declared;
          if (free_any || lru_any) begin
            entry_valid_nxt[wr_idx] = 1'b1;
            pool_busy_nxt[wr_idx]   = 1'b1;
            key_we                  = 1'b1;
            stamp_we                = 1'b1;
            stamp_idx               = wr_idx;
            clock_tick              = 1'b1;
            res_idx                 = wr_idx;
            res_flags.pinned        = 1'b1;
            if (!free_any) begin
              res_flags.spill_needed = 1'b1;
              res_spill_key          = entry_key_r[lru_idx];
            end
          end else if (temp_any) begin
            pool_busy_nxt[temp_idx] = 1'b1;
            res_idx                 = temp_idx;
          end else begin
            res_flags.pool_full = 1'b1;
          end
        end
      end
      CMD_INVAL: begin
        if (hit_any) begin
          entry_valid_nxt[hit_idx] = 1'b0;
          pool_busy_nxt[hit_idx]   = 1'b0;
          res_idx                  = hit_idx;
          res_flags.hit            = 1'b1;
        end
      end
      CMD_ALLOC: begin
        if (temp_any) begin
          pool_busy_nxt[temp_idx] = 1'b1;
          res_idx                 = temp_idx;
        end else begin
          res_flags.pool_full = 1'b1;
        end
      end
      CMD_RELEASE: begin
        use_rel = 1'b1;
        if (rel_in_range) begin
          pool_busy_nxt[rel_idx] = 1'b0;
        end
      end
    endcase
  end

  assign res_reg_num = use_rel ? release_index : REG_W'(res_idx);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      pool_busy_r   <= '0;
      use_clock_r   <= '0;
    end else if (fire) begin
      entry_valid_r <= entry_valid_nxt;
      pool_busy_r   <= pool_busy_nxt;
      if (clock_tick) begin
        use_clock_r <= use_clock_nxt;
      end
    end
  end

  // Keys and stamps are only read while their entry is valid.
  always_ff @(posedge clk) begin
    if (fire && key_we) begin
      entry_key_r[wr_idx] <= var_key;
    end
    if (fire && stamp_we) begin
      entry_stamp_r[stamp_idx] <= use_clock_r;
    end
  end

endmodule

/* sv/lrc_checker.sv */
// Port-level checks for the LRU register cache allocator, bound to the top.
// Depends on lrc_pkg and lru_register_cache_allocator.
`timescale 1ns / 1ps

module lrc_checker #(
  parameter int KEY_WIDTH = lrc_pkg::KEY_WIDTH_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [lrc_pkg::REG_W-1:0] out_reg_num,
  input logic                      out_hit,
  input logic                      out_load_needed,
  input logic                      out_spill_needed,
  input logic [KEY_WIDTH-1:0]      out_spill_key,
  input logic                      out_pinned,
  input logic                      out_pool_full
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result item holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reg_num) &&
    $stable(out_spill_key) && $stable(out_pinned))
    else $error("stalled result item changed");

  // An eviction always pins its register and carries a key only then.
  a_spill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_spill_needed ? (out_pinned && !out_hit)
                                    : (out_spill_key == '0)))
    else $error("spill flags inconsistent");

  // A full pool returns register zero, unpinned.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pool_full |-> out_reg_num == '0 && !out_pinned)
    else $error("pool full result inconsistent");

  // A hit carries no load, spill or pool full flag.
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_load_needed && !out_spill_needed && !out_pool_full)
    else $error("hit result carries miss flags");

endmodule

bind lru_register_cache_allocator lrc_checker #(
  .KEY_WIDTH (KEY_WIDTH)
) u_lrc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_reg_num      (out_reg_num),
  .out_hit          (out_hit),
  .out_load_needed  (out_load_needed),
  .out_spill_needed (out_spill_needed),
  .out_spill_key    (out_spill_key),
  .out_pinned       (out_pinned),
  .out_pool_full    (out_pool_full)
);

/* tb/lru_register_cache_allocator_tb.sv */
// Testbench for lru_register_cache_allocator: directed and random commands
// checked item by item against a behavioral model of the register cache.
// Depends on lrc_pkg and the lru_register_cache_allocator RTL.
`timescale 1ns / 1ps

module lru_register_cache_allocator_tb;
  import lrc_pkg::*;

  localparam int SLOTS        = ENTRIES_DEF;
  localparam int KW           = KEY_WIDTH_DEF;
  localparam int HOT_KEYS     = 12;
  localparam int RAND_ITEMS   = 2000;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;

  // One request item and the result item it should produce.
  typedef struct packed {
    lrc_cmd_t         cmd;
    logic [KW-1:0]    key;
    logic             declared;
    logic [REG_W-1:0] rel;
  } request_t;

  typedef struct packed {
    logic [REG_W-1:0] reg_num;
    logic [KW-1:0]    spill_key;
    lrc_flags_t       flags;
  } grant_t;

  logic             clk              = 1'b0;
  logic             rst_n            = 1'b0;
  logic             in_valid         = 1'b0;
  logic             in_ready;
  logic [CMD_W-1:0] in_cmd           = '0;
  logic [KW-1:0]    in_var_key       = '0;
  logic             in_var_declared  = 1'b0;
  logic [REG_W-1:0] in_release_index = '0;
  logic             out_valid;
  logic             out_ready        = 1'b0;
  logic [REG_W-1:0] out_reg_num;
  logic             out_hit;
  logic             out_load_needed;
  logic             out_spill_needed;
  logic [KW-1:0]    out_spill_key;
  logic             out_pinned;
  logic             out_pool_full;

  lru_register_cache_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_var_key       (in_var_key),
    .in_var_declared  (in_var_declared),
    .in_release_index (in_release_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_reg_num      (out_reg_num),
    .out_hit          (out_hit),
    .out_load_needed  (out_load_needed),
    .out_spill_needed (out_spill_needed),
    .out_spill_key    (out_spill_key),
    .out_pinned       (out_pinned),
    .out_pool_full    (out_pool_full)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t      pending [$];
  grant_t        expected [$];
  logic [KW-1:0] hot [HOT_KEYS];
  int            n_errors = 0;
  int            cycles   = 0;
  logic          quiet    = 1'b0;

  // Model of the register cache: entry flags, keys, use stamps, temp pool.
  logic          slot_cached [SLOTS];
  logic [KW-1:0] slot_key    [SLOTS];
  logic [31:0]   slot_stamp  [SLOTS];
  logic          temp_busy   [SLOTS];
  logic [31:0]   use_clock;

  function automatic int find_var(logic [KW-1:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (slot_cached[i] && slot_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int lowest_idle_temp();
    for (int i = 0; i < SLOTS; i++)
      if (!temp_busy[i]) return i;
    return -1;
  endfunction

  // The use clock sticks at its top value once it gets there.
  function automatic logic [31:0] next_stamp();
    logic [31:0] s;
    s = use_clock;
    if (use_clock != '1) use_clock++;
    return s;
  endfunction

  // Applies one request to the model and returns the result it yields.
  function automatic grant_t grant_for(request_t r);
    grant_t g;
    int     idx;
    g = '0;
    idx = -1;
    case (r.cmd)
      CMD_USE: begin
        idx = find_var(r.key);
        if (idx >= 0) begin
          slot_stamp[idx] = next_stamp();
          g.reg_num = idx[REG_W-1:0];
          g.flags.hit = 1'b1;
          g.flags.pinned = 1'b1;
        end else begin
          // Miss: free register first, then the least recently used entry.
          for (int i = 0; i < SLOTS; i++)
            if (idx < 0 && !slot_cached[i] && !temp_busy[i]) idx = i;
          if (idx < 0) begin
            for (int i = 0; i < SLOTS; i++)
              if (slot_cached[i] && (idx < 0 || slot_stamp[i] < slot_stamp[idx])) idx = i;
            if (idx >= 0) begin
              g.flags.spill_needed = 1'b1;
              g.spill_key = slot_key[idx];
            end
          end
          if (idx >= 0) begin
            slot_cached[idx] = 1'b1;
            slot_key[idx] = r.key;
            slot_stamp[idx] = next_stamp();
            temp_busy[idx] = 1'b1;
            g.reg_num = idx[REG_W-1:0];
            g.flags.pinned = 1'b1;
          end else begin
            // Nothing cached and every temp taken: no temp is idle, so the pool is full.
            idx = lowest_idle_temp();
            if (idx >= 0) begin
              temp_busy[idx] = 1'b1;
              g.reg_num = idx[REG_W-1:0];
            end else begin
              g.flags.pool_full = 1'b1;
            end
          end
          g.flags.load_needed = r.declared;
        end
      end
      CMD_INVAL: begin
        idx = find_var(r.key);
        if (idx >= 0) begin
          slot_cached[idx] = 1'b0;
          temp_busy[idx] = 1'b0;
          g.reg_num = idx[REG_W-1:0];
          g.flags.hit = 1'b1;
        end
      end
      CMD_ALLOC: begin
        idx = lowest_idle_temp();
        if (idx >= 0) begin
          temp_busy[idx] = 1'b1;
          g.reg_num = idx[REG_W-1:0];
        end else begin
          g.flags.pool_full = 1'b1;
        end
      end
      default: begin
        // A release leaves a cached entry valid; only the pool bit clears.
        if (r.rel < SLOTS) temp_busy[r.rel] = 1'b0;
        g.reg_num = r.rel;
      end
    endcase
    return g;
  endfunction

  function automatic void queue_req(lrc_cmd_t c, logic [KW-1:0] k, logic d,
                                    logic [REG_W-1:0] r);
    request_t q;
    q.cmd = c;
    q.key = k;
    q.declared = d;
    q.rel = r;
    pending.push_back(q);
  endfunction

  // Mostly a small set of keys, so hits and evictions are common.
  function automatic logic [KW-1:0] pick_key();
    if ($urandom_range(0, 3) != 0) return hot[$urandom_range(0, HOT_KEYS - 1)];
    return KW'($urandom);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  // Sender: offers queued items with random idle bursts and predicts each
  // item as it is accepted.
  request_t offered;
  int       tx_gap = 0;

  always @(posedge clk) begin
    logic nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      use_clock = '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_cached[i] = 1'b0;
        slot_key[i] = '0;
        slot_stamp[i] = '0;
        temp_busy[i] = 1'b0;
      end
    end else begin
      if (in_valid && in_ready) expected.push_back(grant_for(offered));
      if (!in_valid || in_ready) begin
        nxt_valid = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending.size() != 0) begin
          if (!quiet && $urandom_range(0, 11) == 0) begin
            tx_gap = $urandom_range(1, 13) - 1;
          end else begin
            offered = pending.pop_front();
            nxt_valid = 1'b1;
            in_cmd <= offered.cmd;
            in_var_key <= offered.key;
            in_var_declared <= offered.declared;
            in_release_index <= offered.rel;
          end
        end
        in_valid <= nxt_valid;
      end
      quiet <= (pending.size() < QUIET_TAIL);
    end
  end

  // Receiver: checks each result item, stalls in random bursts and once
  // holds off long enough for the block to back up into its input.
  int   rx_gap    = 0;
  int   hold_left = 0;
  int   n_results = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected.size() == 0) begin
          $error("result item with none expected: reg_num %0d", out_reg_num);
          n_errors++;
        end else begin
          want = expected.pop_front();
          check_field("reg_num", 32'(want.reg_num), 32'(out_reg_num));
          check_field("hit", 32'(want.flags.hit), 32'(out_hit));
          check_field("load_needed", 32'(want.flags.load_needed), 32'(out_load_needed));
          check_field("spill_needed", 32'(want.flags.spill_needed),
                      32'(out_spill_needed));
          check_field("spill_key", 32'(want.spill_key), 32'(out_spill_key));
          check_field("pinned", 32'(want.flags.pinned), 32'(out_pinned));
          check_field("pool_full", 32'(want.flags.pool_full), 32'(out_pool_full));
        end
      end
      if (!hold_done && n_results >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("lru_register_cache_allocator test failed");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int       n;
    int       w;
    int       target;
    lrc_cmd_t c;

    hot[0] = '0;
    hot[1] = '1;
    for (int i = 2; i < HOT_KEYS; i++) hot[i] = KW'($urandom);

    // Fill the temp pool, then overflow it and hit the unpinned fallback.
    repeat (SLOTS) queue_req(CMD_ALLOC, '0, 1'b0, '0);
    queue_req(CMD_ALLOC, '1, 1'b1, '1);
    queue_req(CMD_USE, 16'hFFFF, 1'b1, 3'd0);
    queue_req(CMD_USE, 16'h0000, 1'b0, 3'd7);
    // Invalidate of a key that is not cached.
    queue_req(CMD_INVAL, 16'h1234, 1'b1, 3'd5);
    // Free two temps and cache two variables in them.
    queue_req(CMD_RELEASE, 16'h0000, 1'b0, 3'd7);
    queue_req(CMD_RELEASE, 16'hFFFF, 1'b1, 3'd0);
    queue_req(CMD_USE, 16'hFFFF, 1'b1, 3'd0);
    queue_req(CMD_USE, 16'h8001, 1'b0, 3'd0);
    queue_req(CMD_USE, 16'hFFFF, 1'b0, 3'd0);
    // Every register busy: evict the least recently used variable.
    queue_req(CMD_USE, 16'hAAAA, 1'b1, 3'd2);
    // Release of a register that still holds a cached variable.
    queue_req(CMD_RELEASE, 16'h0000, 1'b0, 3'd0);
    queue_req(CMD_ALLOC, 16'h0000, 1'b0, 3'd0);
    queue_req(CMD_INVAL, 16'hFFFF, 1'b0, 3'd0);
    queue_req(CMD_INVAL, 16'hAAAA, 1'b1, 3'd7);
    queue_req(CMD_USE, 16'h5555, 1'b1, 3'd4);
    queue_req(CMD_RELEASE, 16'h7FFF, 1'b1, 3'd3);

    target = pending.size() + RAND_ITEMS;
    while (pending.size() < target) begin
      if ($urandom_range(0, 5) == 0) begin
        // Invalidate the hot keys, release every register, crowd the pool with temps, then use.
        foreach (hot[i]) queue_req(CMD_INVAL, hot[i], 1'($urandom), REG_W'($urandom));
        for (int r = 0; r < SLOTS; r++)
          queue_req(CMD_RELEASE, pick_key(), 1'($urandom), REG_W'(r));
        n = $urandom_range(SLOTS - 2, SLOTS + 2);
        repeat (n) queue_req(CMD_ALLOC, pick_key(), 1'($urandom), REG_W'($urandom));
        repeat ($urandom_range(1, 4))
          queue_req(CMD_USE, pick_key(), 1'($urandom), REG_W'($urandom));
      end else begin
        // Mixed traffic, weighted toward variable uses.
        repeat ($urandom_range(10, 60)) begin
          w = $urandom_range(0, 99);
          if (w < 50) c = CMD_USE;
          else if (w < 65) c = CMD_INVAL;
          else if (w < 80) c = CMD_ALLOC;
          else c = CMD_RELEASE;
          queue_req(c, pick_key(), 1'($urandom), REG_W'($urandom));
        end
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (pending.size() != 0 || in_valid || expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_errors == 0) $display("lru_register_cache_allocator test passed");
    else $display("lru_register_cache_allocator test failed");
    $finish;
  end

endmodule

/* files.f */
sv/lrc_pkg.sv
sv/lrc_lru_tree.sv
sv/lrc_core.sv
sv/lru_register_cache_allocator.sv
sv/lrc_checker.sv
tb/lru_register_cache_allocator_tb.sv
